// ===== hdl/dti_pkg.sv =====
package dti_pkg;

  // Default table depth and fixed field widths
  localparam int TABLE_DEPTH_DEF = 64;
  localparam int MACH_W          = 16;
  localparam int COEFF_W         = 16;
  localparam int ENTRIES_W       = 7;
  localparam int DIV_STEPS       = 32;

  // Item codes
  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_QUERY  = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_FULL  = 2'd3
  } status_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIRST,
    ST_SCAN,
    ST_MUL,
    ST_ABS,
    ST_DIV,
    ST_FIX,
    ST_POST
  } state_t;

  // Input and result words
  typedef struct packed {
    logic [1:0]                action;
    logic [MACH_W-1:0]         entry_mach;
    logic signed [COEFF_W-1:0] entry_coeff;
    logic [MACH_W-1:0]         query_mach;
  } in_item_t;

  typedef struct packed {
    logic signed [COEFF_W-1:0] coeff;
    logic [1:0]                status;
    logic [ENTRIES_W-1:0]      entries;
  } out_item_t;

  // One table row as held in the memory
  typedef struct packed {
    logic [MACH_W-1:0]         mach;
    logic signed [COEFF_W-1:0] coeff;
  } entry_t;

endpackage

// ===== hdl/drag_table_interpolator.sv =====
// Channel  Direction  Handshake          Word
// cfg      in         cfg_write          cfg_data   (strict range flag)
// in       in         in_valid/in_stall  in_data    (dti_pkg::in_item_t)
// out      out        out_valid/out_stall out_data  (dti_pkg::out_item_t)
//
// Clear, append and unused codes go from accept straight to the result stage.
// A query scans the table one row per cycle through the single memory read port,
// then, when it interpolates, passes through multiply, magnitude, a 32-step serial
// divider and the final add.
// Synchronous reset empties the table and sets strict range; no clearing pass.
// The result sits in an output register; while it is stalled the block can
// take a new word, and holds the next result until the register frees.
module drag_table_interpolator #(
  parameter int TABLE_DEPTH = dti_pkg::TABLE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic               cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  dti_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output dti_pkg::out_item_t out_data
);

  localparam int AW  = $clog2(TABLE_DEPTH);
  localparam int CW  = $clog2(TABLE_DEPTH + 1);
  localparam int EW  = (CW > dti_pkg::ENTRIES_W) ? CW : dti_pkg::ENTRIES_W;
  localparam int DCW = $clog2(dti_pkg::DIV_STEPS);

  dti_pkg::state_t state, state_next;

  // Table state
  dti_pkg::entry_t mem [TABLE_DEPTH];
  dti_pkg::entry_t rd_data;
  dti_pkg::entry_t prev;
  logic [AW-1:0]   rd_addr;
  logic [AW-1:0]   idx;
  logic [CW-1:0]   cnt;
  logic [15:0]     min_mach;
  logic [15:0]     max_mach;
  logic            strict;

  // Arithmetic datapath
  logic [15:0]        qm;
  logic signed [15:0] c0;
  logic signed [16:0] dc;
  logic [15:0]        dq;
  logic [15:0]        wd;
  logic signed [33:0] prod;
  logic signed [33:0] mag;
  logic               neg;
  logic [15:0]        rem;
  logic [31:0]        quo;
  logic [DCW-1:0]     dcnt;
  logic [16:0]        shifted;
  logic [17:0]        diff;
  logic               ge;
  logic [17:0]        qx;
  logic [17:0]        sum;

  // Pending result
  logic signed [15:0] res_coeff;
  dti_pkg::status_t   res_status;
  logic [EW-1:0]      cnt_ext;

  logic in_acc;
  logic full;
  logic q_reject;
  logic hit;
  logic zero_w;
  logic at_last;
  logic load_out;

  assign in_stall = (state != dti_pkg::ST_IDLE);
  assign in_acc   = in_valid && (state == dti_pkg::ST_IDLE);
  assign full     = (cnt == CW'(TABLE_DEPTH));
  assign q_reject = (cnt == '0) ||
                    (strict && ((in_data.query_mach < min_mach) ||
                                (in_data.query_mach > max_mach)));
  assign hit      = (qm >= prev.mach) && (qm <= rd_data.mach);
  assign zero_w   = (prev.mach == rd_data.mach);
  assign at_last  = (CW'(idx) == cnt - CW'(1));
  assign cnt_ext  = EW'(cnt);

  // Divider step and final correction
  assign mag     = prod[33] ? -prod : prod;
  assign shifted = {rem, quo[31]};
  assign diff    = {1'b0, shifted} - {2'b00, wd};
  assign ge      = !diff[17];
  assign qx      = {1'b0, quo[16:0]};
  assign sum     = {{2{c0[15]}}, c0} + (neg ? -qx : qx);

  // Sequencer: next state and memory read address
  always_comb begin
    state_next = state;
    rd_addr    = '0;
    load_out   = 1'b0;
    unique case (state)
      dti_pkg::ST_IDLE: begin
        if (in_valid) begin
          if ((in_data.action == dti_pkg::ACT_QUERY) && !q_reject) begin
            state_next = dti_pkg::ST_FIRST;
          end else begin
            state_next = dti_pkg::ST_POST;
          end
        end
      end
      dti_pkg::ST_FIRST: begin
        if (cnt == CW'(1)) begin
          state_next = dti_pkg::ST_POST;
        end else begin
          rd_addr    = AW'(1);
          state_next = dti_pkg::ST_SCAN;
        end
      end
      dti_pkg::ST_SCAN: begin
        if (hit) begin
          state_next = zero_w ? dti_pkg::ST_POST : dti_pkg::ST_MUL;
        end else if (at_last) begin
          state_next = dti_pkg::ST_POST;
        end else begin
          rd_addr = idx + AW'(1);
        end
      end
      dti_pkg::ST_MUL: state_next = dti_pkg::ST_ABS;
      dti_pkg::ST_ABS: state_next = dti_pkg::ST_DIV;
      dti_pkg::ST_DIV: begin
        if (dcnt == DCW'(dti_pkg::DIV_STEPS - 1)) begin
          state_next = dti_pkg::ST_FIX;
        end
      end
      dti_pkg::ST_FIX: state_next = dti_pkg::ST_POST;
      dti_pkg::ST_POST: begin
        load_out = !out_valid || !out_stall;
        if (load_out) begin
          state_next = dti_pkg::ST_IDLE;
        end
      end
      default: state_next = dti_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dti_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control state: count, Mach bounds, mode, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      min_mach  <= '0;
      max_mach  <= '0;
      strict    <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        strict <= cfg_data;
      end
      if (in_acc) begin
        if (in_data.action == dti_pkg::ACT_CLEAR) begin
          cnt      <= '0;
          min_mach <= '0;
          max_mach <= '0;
        end else if ((in_data.action == dti_pkg::ACT_APPEND) && !full) begin
          cnt <= cnt + CW'(1);
          if ((cnt == '0) || (in_data.entry_mach < min_mach)) begin
            min_mach <= in_data.entry_mach;
          end
          if ((cnt == '0) || (in_data.entry_mach > max_mach)) begin
            max_mach <= in_data.entry_mach;
          end
        end
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (in_acc && (in_data.action == dti_pkg::ACT_APPEND) && !full) begin
      mem[cnt[AW-1:0]] <= {in_data.entry_mach, in_data.entry_coeff};
    end
    rd_data <= mem[rd_addr];
  end

  // Datapath: scan, multiply, serial divide, result
  always_ff @(posedge clk) begin
    unique case (state)
      dti_pkg::ST_IDLE: begin
        if (in_valid) begin
          qm        <= in_data.query_mach;
          res_coeff <= '0;
          unique case (in_data.action)
            dti_pkg::ACT_APPEND: res_status <= full ? dti_pkg::STAT_FULL : dti_pkg::STAT_OK;
            dti_pkg::ACT_QUERY: begin
              if (cnt == '0) begin
                res_status <= dti_pkg::STAT_EMPTY;
              end else if (q_reject) begin
                res_status <= dti_pkg::STAT_RANGE;
              end else begin
                res_status <= dti_pkg::STAT_OK;
              end
            end
            default: res_status <= dti_pkg::STAT_OK;
          endcase
        end
      end
      dti_pkg::ST_FIRST: begin
        prev      <= rd_data;
        idx       <= AW'(1);
        res_coeff <= rd_data.coeff;
      end
      dti_pkg::ST_SCAN: begin
        prev      <= rd_data;
        idx       <= idx + AW'(1);
        res_coeff <= hit ? prev.coeff : rd_data.coeff;
        c0        <= prev.coeff;
        dc        <= {rd_data.coeff[15], rd_data.coeff} - {prev.coeff[15], prev.coeff};
        dq        <= qm - prev.mach;
        wd        <= rd_data.mach - prev.mach;
      end
      dti_pkg::ST_MUL: begin
        prod <= dc * $signed({1'b0, dq});
      end
      dti_pkg::ST_ABS: begin
        neg  <= prod[33];
        rem  <= '0;
        quo  <= mag[31:0];
        dcnt <= '0;
      end
      dti_pkg::ST_DIV: begin
        rem  <= ge ? diff[15:0] : shifted[15:0];
        quo  <= {quo[30:0], ge};
        dcnt <= dcnt + DCW'(1);
      end
      dti_pkg::ST_FIX: begin
        res_coeff <= sum[15:0];
      end
      dti_pkg::ST_POST: begin
        if (load_out) begin
          out_data.coeff   <= res_coeff;
          out_data.status  <= res_status;
          out_data.entries <= cnt_ext[dti_pkg::ENTRIES_W-1:0];
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== verif/drag_table_interpolator_test.sv =====
module drag_table_interpolator_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] ACT_UNUSED  = 2'd3;
  localparam int         ITEM_TARGET = 650;
  localparam int         CYCLE_LIMIT = 600_000;
  localparam int         DRAIN_WAIT  = 150;
  localparam int         MAX_REPORTS = 10;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write = 1'b0;
  logic               cfg_data = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  dti_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  dti_pkg::out_item_t out_data;

  // Predictor state: table rows, Mach bounds and the strict flag
  logic [15:0]        mach_rows [dti_pkg::TABLE_DEPTH_DEF];
  logic signed [15:0] coeff_rows [dti_pkg::TABLE_DEPTH_DEF];
  int                 row_count = 0;
  logic [15:0]        mach_lo = '0;
  logic [15:0]        mach_hi = '0;
  bit                 strict_mode = 1'b1;

  dti_pkg::out_item_t pending_results [$];

  // Run bookkeeping
  bit idle_on = 1'b1;
  int stall_left = 0;
  int hold_req = 0;
  int cycle_count = 0;
  int items_sent = 0;
  int results_checked = 0;
  int fail_count = 0;
  int cfg_writes = 0;
  int input_held_cycles = 0;
  int status_seen [4] = '{0, 0, 0, 0};

  drag_table_interpolator u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Cycle limit and input back-pressure count
  always @(posedge clk) begin
    cycle_count++;
    if (!rst && in_valid && in_stall === 1'b1) input_held_cycles++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Linear interpolation over the first enclosing segment, truncating division
  function automatic logic [15:0] interp_drag(logic [15:0] q);
    longint c0, c1, m0, m1, span, res;
    for (int i = 0; i + 1 < row_count; i++) begin
      if (q >= mach_rows[i] && q <= mach_rows[i + 1]) begin
        m0 = mach_rows[i];
        m1 = mach_rows[i + 1];
        c0 = coeff_rows[i];
        c1 = coeff_rows[i + 1];
        span = m1 - m0;
        // equal breakpoints: first coefficient of the segment
        if (span == 0) return c0[15:0];
        res = c0 + ((c1 - c0) * (longint'(q) - m0)) / span;
        return res[15:0];
      end
    end
    // no segment encloses q: last coefficient
    return coeff_rows[row_count - 1];
  endfunction

  // Expected result word for one accepted input word; updates the table
  function automatic dti_pkg::out_item_t predict_drag_word(dti_pkg::in_item_t w);
    dti_pkg::out_item_t r;
    r.coeff  = '0;
    r.status = dti_pkg::STAT_OK;
    case (w.action)
      dti_pkg::ACT_CLEAR: begin
        row_count = 0;
        mach_lo   = '0;
        mach_hi   = '0;
      end
      dti_pkg::ACT_APPEND: begin
        if (row_count >= dti_pkg::TABLE_DEPTH_DEF) begin
          r.status = dti_pkg::STAT_FULL;
        end else begin
          mach_rows[row_count]  = w.entry_mach;
          coeff_rows[row_count] = w.entry_coeff;
          if (row_count == 0) begin
            mach_lo = w.entry_mach;
            mach_hi = w.entry_mach;
          end else begin
            if (w.entry_mach < mach_lo) mach_lo = w.entry_mach;
            if (w.entry_mach > mach_hi) mach_hi = w.entry_mach;
          end
          row_count++;
        end
      end
      dti_pkg::ACT_QUERY: begin
        if (row_count == 0) r.status = dti_pkg::STAT_EMPTY;
        else if (strict_mode && (w.query_mach < mach_lo || w.query_mach > mach_hi))
          r.status = dti_pkg::STAT_RANGE;
        else r.coeff = interp_drag(w.query_mach);
      end
      default: ;
    endcase
    r.entries = row_count[6:0];
    return r;
  endfunction

  // Result check against the oldest expectation; also draws the next stall
  always @(posedge clk) begin : result_check
    dti_pkg::out_item_t want;
    if (!rst) begin
      if (out_valid === 1'b1 && !out_stall) begin
        if (pending_results.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("unexpected result: coeff %0d status %0d entries %0d",
                     out_data.coeff, out_data.status, out_data.entries);
        end else begin
          want = pending_results.pop_front();
          status_seen[want.status]++;
          if (out_data.coeff !== want.coeff || out_data.status !== want.status ||
              out_data.entries !== want.entries) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display({"result %0d: expected coeff %0d status %0d entries %0d,",
                        " got coeff %0d status %0d entries %0d"},
                       results_checked, want.coeff, want.status, want.entries,
                       out_data.coeff, out_data.status, out_data.entries);
          end
        end
        results_checked++;
        stall_left = idle_on ? $urandom_range(0, 5) : 0;
      end
      // long hold-off requested by a test
      if (hold_req > 0) begin
        stall_left = hold_req;
        hold_req   = 0;
      end
    end
  end

  // Receiver stall, counted down in cycles
  always @(negedge clk) begin
    out_stall <= (stall_left > 0);
    if (stall_left > 0) stall_left--;
  end

  function automatic logic [15:0] rand16();
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic logic [15:0] pick_coeff();
    case ($urandom_range(0, 15))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return rand16();
    endcase
  endfunction

  // Query Mach: mostly inside segments or on breakpoints, some outside the range
  function automatic logic [15:0] pick_query();
    int sel, k;
    int a, b;
    sel = $urandom_range(0, 99);
    if (row_count == 0 || sel >= 90) return rand16();
    if (sel < 8) return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
    if (sel < 28) return mach_rows[$urandom_range(0, row_count - 1)];
    if (sel < 62 && row_count > 1) begin
      k = $urandom_range(0, row_count - 2);
      a = mach_rows[k];
      b = mach_rows[k + 1];
      return (a <= b) ? 16'($urandom_range(a, b)) : 16'($urandom_range(b, a));
    end
    if (sel < 70) return (mach_lo > 0) ? mach_lo - 16'd1 : 16'h0000;
    if (sel < 78) return (mach_hi < 16'hFFFF) ? mach_hi + 16'd1 : 16'hFFFF;
    return 16'($urandom_range(mach_lo, mach_hi));
  endfunction

  // Offer one word after a random gap; returns at the falling edge after acceptance
  // with valid still high, so a following word can go out back to back
  task automatic send_word(logic [1:0] act, logic [15:0] emach, logic [15:0] ecoeff,
                           logic [15:0] qmach);
    dti_pkg::in_item_t  w;
    dti_pkg::out_item_t exp_word;
    int gap;
    w.action      = act;
    w.entry_mach  = emach;
    w.entry_coeff = ecoeff;
    w.query_mach  = qmach;
    gap = idle_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall !== 1'b0);
    exp_word = predict_drag_word(w);
    pending_results = {pending_results, exp_word};
    items_sent++;
    @(negedge clk);
  endtask

  task automatic clear_table();
    send_word(dti_pkg::ACT_CLEAR, rand16(), rand16(), rand16());
  endtask

  task automatic append_row(logic [15:0] m, logic [15:0] c);
    send_word(dti_pkg::ACT_APPEND, m, c, rand16());
  endtask

  task automatic query_at(logic [15:0] q);
    send_word(dti_pkg::ACT_QUERY, rand16(), rand16(), q);
  endtask

  task automatic send_unused();
    send_word(ACT_UNUSED, rand16(), rand16(), rand16());
  endtask

  // Stop offering and wait until every expected result is in
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
  endtask

  task automatic set_strict(bit v);
    wait_drained();
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(negedge clk);
    cfg_write   <= 1'b0;
    strict_mode = v;
    cfg_writes++;
  endtask

  // Strict range: empty table, single row, bounds, zero-width segment, no match
  task automatic test_directed_strict();
    set_strict(1'b1);
    query_at(16'd500);
    append_row(16'd100, 16'h8000);
    query_at(16'd100);
    query_at(16'd99);
    query_at(16'hFFFF);
    append_row(16'd100, 16'h7FFF);
    query_at(16'd100);
    append_row(16'hFFFF, 16'h0000);
    query_at(16'hFFFF);
    query_at(16'd3000);
    append_row(16'd0, 16'd1234);
    query_at(16'd0);
    send_unused();
    clear_table();
    query_at(16'd0);
  endtask

  // Lenient range: outside queries take the last coefficient; truncation toward zero
  task automatic test_directed_lenient();
    set_strict(1'b0);
    append_row(16'd1000, 16'd500);
    append_row(16'd2000, 16'hFE0C);
    query_at(16'd0);
    query_at(16'hFFFF);
    query_at(16'd1001);
    query_at(16'd1999);
    clear_table();
    append_row(16'd0, 16'd0);
    append_row(16'd3, 16'hFFFF);
    query_at(16'd2);
    append_row(16'd6, 16'h7FFF);
    query_at(16'd4);
  endtask

  // Fill the table, then appends are refused and the count stays at the depth
  task automatic test_full_table();
    int m;
    clear_table();
    m = $urandom_range(0, 200);
    for (int i = 0; i < dti_pkg::TABLE_DEPTH_DEF; i++) begin
      append_row(m[15:0], pick_coeff());
      m += $urandom_range(0, 1000);
    end
    repeat (3) append_row(rand16(), pick_coeff());
    repeat (6) query_at(pick_query());
    set_strict(1'b0);
    repeat (4) query_at(pick_query());
    query_at(16'hFFFF);
    set_strict(1'b1);
    clear_table();
  endtask

  // Receiver holds off long enough for the block to stall its input
  task automatic test_output_backpressure();
    wait_drained();
    idle_on = 1'b0;
    clear_table();
    repeat (4) append_row(rand16(), pick_coeff());
    wait_drained();
    hold_req = 300;
    repeat (24) begin
      if ($urandom_range(0, 3) == 0) append_row(rand16(), pick_coeff());
      else query_at(pick_query());
    end
    // sender pauses here until the backlog has drained
    wait_drained();
    idle_on  = 1'b1;
    hold_req = 150;
    repeat (12) query_at(pick_query());
    wait_drained();
  endtask

  // One table: optional clear, a run of appends (mostly ascending), then queries
  task automatic run_table_session();
    int n_app, shape, m, stride, sel;
    if ($urandom_range(0, 4) != 0) begin
      clear_table();
      if ($urandom_range(0, 6) == 0) query_at(rand16());
    end
    sel = $urandom_range(0, 99);
    if (sel < 70) n_app = $urandom_range(1, 8);
    else if (sel < 90) n_app = $urandom_range(9, 24);
    else if (sel < 97) n_app = $urandom_range(25, 64);
    else n_app = $urandom_range(60, 70);
    // ascending, ascending with repeated breakpoints, or scattered
    shape = $urandom_range(0, 99);
    m = $urandom_range(0, 8000);
    for (int i = 0; i < n_app; i++) begin
      if (shape >= 80) begin
        m = $urandom_range(0, 65535);
      end else if (i > 0) begin
        if (shape >= 60 && $urandom_range(0, 3) == 0) stride = 0;
        else stride = $urandom_range(1, ($urandom_range(0, 1) != 0) ? 500 : 6000);
        m = (m + stride > 65535) ? 65535 : m + stride;
      end
      append_row(m[15:0], pick_coeff());
      if ($urandom_range(0, 9) == 0) query_at(pick_query());
      if ($urandom_range(0, 29) == 0) send_unused();
    end
    repeat ($urandom_range(2, 10)) query_at(pick_query());
  endtask

  task automatic test_random_sessions();
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 3) == 0) set_strict(1'($urandom_range(0, 1)));
      idle_on = ($urandom_range(0, 4) != 0);
      run_table_session();
    end
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    test_directed_strict();
    test_directed_lenient();
    test_full_table();
    test_output_backpressure();
    test_random_sessions();
    wait_drained();
    repeat (DRAIN_WAIT) @(negedge clk);
    $display("summary: %0d words in, %0d results (ok %0d, out of range %0d, %s",
             items_sent, results_checked, status_seen[dti_pkg::STAT_OK],
             status_seen[dti_pkg::STAT_RANGE],
             $sformatf("empty %0d, full %0d)", status_seen[dti_pkg::STAT_EMPTY],
                       status_seen[dti_pkg::STAT_FULL]));
    $display("summary: %0d range-mode writes, input held off %0d cycles, %0d mismatches",
             cfg_writes, input_held_cycles, fail_count);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/dti_pkg.sv
hdl/drag_table_interpolator.sv
verif/drag_table_interpolator_test.sv
